// ===== sv/wsr_pkg.sv =====
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared constants and elaboration-time coefficient math for the resampler.
// ----------------------------------------------------------------------------
package wsr_pkg;

	localparam int COEF_W = 18;
	localparam int SAMPLE_W = 16;
	localparam int POS_W = 48;
	localparam int STEP_W = 20;
	localparam int SEEN_W = 32;
	localparam int MAX_RESULTS = 44;
	localparam logic [STEP_W-1:0] STEP_ONE = 20'd65536;
	localparam logic [STEP_W-1:0] STEP_MIN = 20'd16384;

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_FLUSH = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint ONE_Q30 = 64'sd1073741824;

	// unsigned quotient by shift and subtract
	function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// sin(pi*num/den) in signed Q30, Taylor series after quarter-wave folding
	function automatic longint sin_pi(longint num, longint den);
		longint m;
		bit neg;
		longint unsigned u30;
		longint unsigned y;
		longint unsigned term;
		longint sum;
		m = num - 2 * den * longint'(udiv(num, 2 * den));
		neg = 1'b0;
		if (m >= den) begin
			m = m - den;
			neg = 1'b1;
		end
		if (2 * m > den) m = den - m;
		u30 = udiv(longint'(m) << 30, den);
		y = (u30 * PI_Q30) >> 30;
		sum = longint'(y);
		term = y;
		for (int i = 1; i <= 7; i++) begin
			term = (((term * y) >> 30) * y) >> 30;
			term = udiv(term, (2 * i) * (2 * i + 1));
			if ((i % 2) == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		return neg ? -sum : sum;
	endfunction

	// Hann-windowed sinc weight in signed Q16 for distance an (units of 1/2^pb)
	function automatic longint coef_q16(longint an, int pb, int hw);
		longint d;
		longint s;
		longint sinc30;
		longint hann30;
		longint unsigned mag;
		longint unsigned prod;
		bit neg;
		d = longint'(1) << pb;
		if (an >= longint'(hw) * d) return 0;
		if (an == 0) begin
			sinc30 = ONE_Q30;
		end else begin
			s = sin_pi(an, d);
			mag = (longint'(s < 0 ? -s : s) * longint'(d)) << 20;
			mag = udiv(mag, (PI_Q30 * longint'(an)) >> 10);
			sinc30 = s < 0 ? -longint'(mag) : longint'(mag);
		end
		s = sin_pi(2 * an + longint'(hw) * d, 2 * longint'(hw) * d);
		hann30 = (ONE_Q30 + s) / 2;
		neg = sinc30 < 0;
		prod = longint'(neg ? -sinc30 : sinc30) * longint'(hann30);
		mag = (prod + (longint'(1) << 43)) >> 44;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

endpackage

// ===== sv/wsr_ram.sv =====
// ----------------------------------------------------------------------------
// wsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/wsr_coef_rom.sv =====
// ----------------------------------------------------------------------------
// wsr_coef_rom
// Hann-windowed sinc weight ROM indexed by tap distance, registered output.
// ----------------------------------------------------------------------------
module wsr_coef_rom #(
	parameter int HALF_TAPS = 8,
	parameter int PHASE_BITS = 8
) (
	input  logic                                        clk,
	input  logic [$clog2(HALF_TAPS*(2**PHASE_BITS))-1:0] idx,
	input  logic                                        in_range,
	output logic signed [wsr_pkg::COEF_W-1:0]           coef
);

	localparam int ENTRIES = HALF_TAPS * (2 ** PHASE_BITS);
	localparam int CW = wsr_pkg::COEF_W;

	logic signed [CW-1:0] tbl [ENTRIES];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_tbl
		localparam logic signed [CW-1:0] C =
			CW'(wsr_pkg::coef_q16(longint'(i), PHASE_BITS, HALF_TAPS));
		assign tbl[i] = C;
	end

	always_ff @(posedge clk) begin
		coef <= in_range ? tbl[idx] : '0;
	end

endmodule

// ===== sv/windowed_sinc_resampler.sv =====
// ----------------------------------------------------------------------------
// windowed_sinc_resampler
// Hann-windowed sinc sample-rate converter with a shared MAC and divider.
// ----------------------------------------------------------------------------
//  channel  signals                               dir
//  in       in_valid, in_stall, req_type, sample_in  sink
//  out      out_valid, out_stall, sample_out, last_out  source
//  cfg      step_wr_en, step_wr_data              sink
//
// Each result runs three tap states per tap (2*HALF_TAPS taps), then the
// normalizing divider at one quotient bit per cycle (ACCW bits), then control
// states; the divider is skipped when the weight sum is not positive. in_stall
// is high from accept until the transaction ends, after its last result, if any,
// is loaded into the output register.
// arst_n clears the sequencer, counters, position and step (to passthrough).
// out_stall only holds the output register; the sequencer waits on it.
// ----------------------------------------------------------------------------
module windowed_sinc_resampler #(
	parameter int HALF_TAPS = 8,
	parameter int RING_DEPTH = 32,
	parameter int PHASE_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_wr_en,
	input  logic [19:0]         step_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic signed [15:0]  sample_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  sample_out,
	output logic                last_out
);

	localparam int TAPS = 2 * HALF_TAPS;
	localparam int TW = $clog2(TAPS);
	localparam int RAW = $clog2(RING_DEPTH);
	localparam int D = 2 ** PHASE_BITS;
	localparam int IW = $clog2(HALF_TAPS * D);
	localparam int NW = PHASE_BITS + TW + 2;
	localparam int PW = wsr_pkg::COEF_W + wsr_pkg::SAMPLE_W;
	localparam int ACCW = PW + TW + 1;
	localparam int WSW = wsr_pkg::COEF_W + TW + 1;
	localparam int CW = $clog2(ACCW + 1);
	localparam int RW = $clog2(wsr_pkg::MAX_RESULTS + 1);
	localparam logic signed [47:0] LIM_SAMPLE = -(48'(HALF_TAPS + 2) << 16);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHECK = 9'b000000010,
		S_TAP_A = 9'b000000100,
		S_TAP_M = 9'b000001000,
		S_TAP_C = 9'b000010000,
		S_DIV0  = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [19:0] step_q;
	logic [31:0] seen_q;
	logic [47:0] pos_q;
	logic [RAW-1:0] wptr_q;
	logic flush_q;
	logic [RW-1:0] count_q;
	logic pend_q;
	logic pend_last_q;
	logic signed [15:0] res_q;
	logic [TW-1:0] tap_q;
	logic tap_ok_q;
	logic tap_ok2_q;
	logic signed [PW-1:0] prod_q;
	logic signed [wsr_pkg::COEF_W-1:0] coef2_q;
	logic signed [ACCW-1:0] acc_q;
	logic signed [WSW-1:0] wsum_q;
	logic neg_q;
	logic [ACCW-1:0] num_q;
	logic [ACCW-1:0] quot_q;
	logic [WSW:0] rem_q;
	logic [CW-1:0] dcnt_q;
	logic out_valid_q;
	logic signed [15:0] sample_out_q;
	logic last_out_q;

	logic pass;
	logic [19:0] step_eff;
	logic in_fire;
	logic [47:0] diff;
	logic more;
	logic [31:0] back;
	logic tap_ok;
	logic [RAW-1:0] newest;
	logic [RAW:0] addr_tmp;
	logic [RAW-1:0] raddr;
	logic signed [NW-1:0] n_dist;
	logic [NW-1:0] an;
	logic an_in;
	logic signed [wsr_pkg::COEF_W-1:0] coef;
	logic [15:0] ram_rdata;
	logic [ACCW-1:0] mag;
	logic [WSW:0] rem_sh;
	logic out_free;
	logic emit_fire;

	assign pass = step_q == wsr_pkg::STEP_ONE;
	assign step_eff = (step_q < wsr_pkg::STEP_MIN) ? wsr_pkg::STEP_MIN : step_q;
	assign in_stall = state_q != S_IDLE;
	assign in_fire = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign emit_fire = (state_q == S_EMIT) && out_free;

	assign diff = pos_q - {seen_q, 16'h0};
	assign more = (count_q < RW'(wsr_pkg::MAX_RESULTS)) &&
		(flush_q ? diff[47] : ($signed(diff) < LIM_SAMPLE));

	assign back = seen_q - pos_q[47:16] + 32'(HALF_TAPS - 2) - 32'(tap_q);
	assign tap_ok = (back < 32'(RING_DEPTH)) && (back < seen_q);
	assign newest = (wptr_q == '0) ? RAW'(RING_DEPTH - 1) : wptr_q - 1'b1;
	assign addr_tmp = {1'b0, newest} - {1'b0, back[RAW-1:0]};
	assign raddr = addr_tmp[RAW] ? RAW'(addr_tmp + (RAW+1)'(RING_DEPTH)) : addr_tmp[RAW-1:0];

	assign n_dist = (NW'(tap_q) << PHASE_BITS) - NW'((HALF_TAPS - 1) * D)
		- NW'(pos_q[15:16-PHASE_BITS]);
	assign an = n_dist[NW-1] ? NW'(-n_dist) : NW'(n_dist);
	assign an_in = an < NW'(HALF_TAPS * D);

	assign mag = acc_q[ACCW-1] ? ACCW'(-acc_q) : ACCW'(acc_q);
	assign rem_sh = {rem_q[WSW-1:0], num_q[ACCW-1]};

	wsr_ram #(
		.WIDTH(16),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk(clk),
		.we(in_fire && req_type == wsr_pkg::REQ_SAMPLE && !pass),
		.waddr(wptr_q),
		.wdata(sample_in),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	wsr_coef_rom #(
		.HALF_TAPS(HALF_TAPS),
		.PHASE_BITS(PHASE_BITS)
	) u_rom (
		.clk(clk),
		.idx(an[IW-1:0]),
		.in_range(an_in),
		.coef(coef)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= wsr_pkg::STEP_ONE;
			seen_q <= '0;
			pos_q <= '0;
			wptr_q <= '0;
			flush_q <= 1'b0;
			count_q <= '0;
			pend_q <= 1'b0;
			pend_last_q <= 1'b0;
			tap_q <= '0;
			dcnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step_wr_en) step_q <= step_wr_data;
			if (emit_fire) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						count_q <= '0;
						pend_q <= 1'b0;
						unique case (req_type)
							wsr_pkg::REQ_SAMPLE: begin
								if (pass) begin
									res_q <= sample_in;
									pend_last_q <= 1'b1;
									state_q <= S_EMIT;
								end else begin
									wptr_q <= (wptr_q == RAW'(RING_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
									seen_q <= seen_q + 32'd1;
									flush_q <= 1'b0;
									state_q <= S_CHECK;
								end
							end
							wsr_pkg::REQ_FLUSH: begin
								if (!pass) begin
									flush_q <= 1'b1;
									state_q <= S_CHECK;
								end
							end
							wsr_pkg::REQ_RESTART: begin
								seen_q <= '0;
								pos_q <= '0;
								wptr_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_CHECK: begin
					tap_q <= '0;
					acc_q <= '0;
					wsum_q <= '0;
					if (pend_q) begin
						pend_last_q <= !more;
						state_q <= S_EMIT;
					end else if (more) begin
						state_q <= S_TAP_A;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_TAP_A: begin
					tap_ok_q <= tap_ok;
					state_q <= S_TAP_M;
				end
				S_TAP_M: begin
					prod_q <= coef * $signed(ram_rdata);
					coef2_q <= coef;
					tap_ok2_q <= tap_ok_q;
					state_q <= S_TAP_C;
				end
				S_TAP_C: begin
					if (tap_ok2_q) begin
						acc_q <= acc_q + ACCW'(prod_q);
						wsum_q <= wsum_q + WSW'(coef2_q);
					end
					tap_q <= tap_q + 1'b1;
					state_q <= (tap_q == TW'(TAPS - 1)) ? S_DIV0 : S_TAP_A;
				end
				S_DIV0: begin
					neg_q <= acc_q[ACCW-1];
					rem_q <= '0;
					dcnt_q <= CW'(ACCW);
					if (wsum_q > 0) begin
						num_q <= mag + ACCW'(wsum_q >>> 1);
						state_q <= S_DIV;
					end else begin
						quot_q <= (mag + ACCW'(32768)) >> 16;
						state_q <= S_FIN;
					end
				end
				S_DIV: begin
					num_q <= num_q << 1;
					if (rem_sh >= (WSW+1)'(wsum_q)) begin
						rem_q <= rem_sh - (WSW+1)'(wsum_q);
						quot_q <= {quot_q[ACCW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quot_q <= {quot_q[ACCW-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == CW'(1)) state_q <= S_FIN;
				end
				S_FIN: begin
					if (neg_q) res_q <= (quot_q >= ACCW'(32768)) ? 16'sh8000 : -$signed(quot_q[15:0]);
					else res_q <= (quot_q > ACCW'(32767)) ? 16'sh7fff : $signed(quot_q[15:0]);
					pos_q <= pos_q + 48'(step_eff);
					count_q <= count_q + 1'b1;
					pend_q <= 1'b1;
					state_q <= S_CHECK;
				end
				S_EMIT: begin
					if (out_free) begin
						sample_out_q <= res_q;
						last_out_q <= pend_last_q;
						pend_q <= 1'b0;
						state_q <= pend_last_q ? S_IDLE : S_TAP_A;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign last_out = last_out_q;

endmodule
